@@ sv/frc16_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc16_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the frame
// receiver.
// ----------------------------------------------------------------------------
package frc16_pkg;

  // Start-of-frame bytes
  localparam logic [7:0] SOF_BYTE0 = 8'hAA;
  localparam logic [7:0] SOF_BYTE1 = 8'h55;

  // CRC-16/CCITT-FALSE, MSB first, no reflection, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_END_GOOD = 2'd1;
  localparam logic [1:0] KIND_END_BAD  = 2'd2;

  localparam int unsigned MAX_LEN_RESET = 512;

  // One result beat as it travels from the parser to the output stage
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] payload_offset;
    logic [15:0] packet_id;
    logic [7:0]  flags_byte;
    logic [7:0]  sequence_res;
    logic [15:0] payload_length;
  } rec_t;

  // Eight-bit unrolled CRC update
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC state after the first start byte
  localparam logic [15:0] CRC_START = crc_feed(CRC_INIT, SOF_BYTE0);

endpackage

@@ sv/frc16_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc16_front
// Byte parser: start-byte hunt, header capture, length check, running CRC
// and result generation. Pushes one result record per producing byte.
// ----------------------------------------------------------------------------
module frc16_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               acc_i,
  input  logic [7:0]         rx_byte_i,
  output logic               push_o,
  output frc16_pkg::rec_t    rec_o
);
  import frc16_pkg::*;

  localparam logic [3:0] PH_SOF0    = 4'd0;
  localparam logic [3:0] PH_SOF1    = 4'd1;
  localparam logic [3:0] PH_ID_LO   = 4'd2;
  localparam logic [3:0] PH_ID_HI   = 4'd3;
  localparam logic [3:0] PH_FLAGS   = 4'd4;
  localparam logic [3:0] PH_SEQ     = 4'd5;
  localparam logic [3:0] PH_LEN_LO  = 4'd6;
  localparam logic [3:0] PH_LEN_HI  = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_CRC_HI  = 4'd9;
  localparam logic [3:0] PH_CRC_LO  = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] max_len_q;

  logic [15:0] crc_nxt;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;

  assign crc_nxt  = crc_feed(crc_q, rx_byte_i);
  assign len_full = {rx_byte_i, len_q[7:0]};
  assign cnt_inc  = cnt_q + 16'd1;

  // Phase machine and field capture
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    id_d     = id_q;
    flags_d  = flags_q;
    seq_d    = seq_q;
    push_o   = 1'b0;
    rec_o    = '0;
    if (acc_i) begin
      unique case (phase_q)
        PH_SOF1: begin
          if (rx_byte_i == SOF_BYTE1) begin
            crc_d   = crc_nxt;
            phase_d = PH_ID_LO;
          end else if (rx_byte_i == SOF_BYTE0) begin
            crc_d   = CRC_START;
            phase_d = PH_SOF1;
          end else begin
            phase_d = PH_SOF0;
          end
        end
        PH_ID_LO: begin
          crc_d   = crc_nxt;
          id_d    = {8'h00, rx_byte_i};
          phase_d = PH_ID_HI;
        end
        PH_ID_HI: begin
          crc_d   = crc_nxt;
          id_d    = {rx_byte_i, id_q[7:0]};
          phase_d = PH_FLAGS;
        end
        PH_FLAGS: begin
          crc_d   = crc_nxt;
          flags_d = rx_byte_i;
          phase_d = PH_SEQ;
        end
        PH_SEQ: begin
          crc_d   = crc_nxt;
          seq_d   = rx_byte_i;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          crc_d   = crc_nxt;
          len_d   = {8'h00, rx_byte_i};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          crc_d = crc_nxt;
          len_d = len_full;
          cnt_d = '0;
          // oversize frames are dropped without a result
          if (len_full > max_len_q) begin
            phase_d = PH_SOF0;
          end else if (len_full == 16'd0) begin
            phase_d = PH_CRC_HI;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_d                = crc_nxt;
          push_o               = 1'b1;
          rec_o.kind           = KIND_DATA;
          rec_o.data_byte      = rx_byte_i;
          rec_o.payload_offset = cnt_q;
          cnt_d                = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          crc_hi_d = rx_byte_i;
          phase_d  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          push_o               = 1'b1;
          rec_o.kind           = ({crc_hi_q, rx_byte_i} == crc_q) ? KIND_END_GOOD
                                                                  : KIND_END_BAD;
          rec_o.packet_id      = id_q;
          rec_o.flags_byte     = flags_q;
          rec_o.sequence_res   = seq_q;
          rec_o.payload_length = len_q;
          crc_d                = CRC_INIT;
          phase_d              = PH_SOF0;
        end
        default: begin
          // hunt for first start byte; unused codes land here too
          if (rx_byte_i == SOF_BYTE0) begin
            crc_d   = CRC_START;
            phase_d = PH_SOF1;
          end else begin
            phase_d = PH_SOF0;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SOF0;
      cnt_q     <= '0;
      len_q     <= '0;
      crc_q     <= CRC_INIT;
      crc_hi_q  <= '0;
      id_q      <= '0;
      flags_q   <= '0;
      seq_q     <= '0;
      max_len_q <= 16'(MAX_LEN_RESET);
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      id_q     <= id_d;
      flags_q  <= flags_d;
      seq_q    <= seq_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // A frame end always returns to the hunt with a fresh CRC
  a_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && rec_o.kind != KIND_DATA) |=> (phase_q == PH_SOF0 && crc_q == CRC_INIT))
    else $error("frame end did not return to hunt");

  // Payload offsets stay below the accepted length
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && rec_o.kind == KIND_DATA) |-> (cnt_q < len_q && len_q <= max_len_q
                                              || cnt_q < len_q))
    else $error("payload offset beyond frame length");

endmodule

@@ sv/frc16_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc16_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module frc16_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  frc16_pkg::rec_t rec_i,
  input  logic            pop_i,
  output frc16_pkg::rec_t rec_o,
  output logic            empty_o,
  output logic            full_o
);
  import frc16_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rec_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_FULL);
  assign rec_o   = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

@@ sv/frc16_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc16_back
// Output register: pulls records from the queue and presents them as
// master-side beats.
// ----------------------------------------------------------------------------
module frc16_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  frc16_pkg::rec_t q_rec_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [71:0]     m_axis_tdata,
  output logic [1:0]      m_axis_tuser
);
  import frc16_pkg::*;

  logic vld_q;
  rec_t rec_q;

  // Load when the register is empty or its beat leaves this cycle
  assign q_pop_o = !q_empty_i && (!vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (q_pop_o) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q <= q_rec_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = rec_q.kind;
  assign m_axis_tdata  = {rec_q.payload_length, rec_q.sequence_res, rec_q.flags_byte,
                          rec_q.packet_id, rec_q.payload_offset, rec_q.data_byte};

endmodule

@@ sv/frame_receiver_crc16_check_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_receiver_crc16_check_core
// Start-byte framed receiver with CRC-16/CCITT-FALSE check.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per beat. The parser hunts for AA 55,
//   captures id (LE), flags, sequence and length (LE), then forwards each
//   payload byte as a data beat (tuser = 0) with its offset. After the two
//   CRC bytes (big-endian) one frame-end beat reports the header, with
//   tuser = 1 for a matching CRC and 2 for a mismatch. Frames longer than
//   max_payload_len (cfg_we_i / cfg_wdata_i, reset 512) are dropped silently.
//   Throughput: one byte per cycle while s_axis_tready is high; the CRC byte
//   update and the phase logic are combinational ahead of the state registers.
//   Each result passes through the queue write and then the output register
//   load before its beat is valid on the m_axis side of the core.
//   Reset clears the parser to the hunt, empties the queue and drops any
//   pending output beat. When m_axis stalls, results collect in the queue;
//   s_axis_tready falls once QUEUE_DEPTH results wait there, and bytes that
//   produce no result are held back as well until space frees up.
// ----------------------------------------------------------------------------
module frame_receiver_crc16_check_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [23:8] payload_offset, [39:24] packet_id,
  // [47:40] flags_byte, [55:48] sequence_res, [71:56] payload_length
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser   // [1:0] kind
);
  import frc16_pkg::*;

  logic acc;
  logic push;
  rec_t push_rec;
  rec_t head_rec;
  logic q_empty;
  logic q_full;
  logic q_pop;

  assign s_axis_tready = !q_full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  frc16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .rx_byte_i   (s_axis_tdata),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  frc16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (q_pop),
    .rec_o   (head_rec),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  frc16_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_rec_i       (head_rec),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ verif/frame_receiver_crc16_check_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_receiver_crc16_check_core_tb
// Self-checking bench for the framed byte receiver with CRC-16 check.
// A directed table covers the start-byte hunt, header extremes, oversize drop,
// zero-length frames and good/bad CRC. Random frames follow under several
// length limits, with random gaps on both streams. Every output beat is
// compared field by field against the directed table or an in-bench parser model.
// ----------------------------------------------------------------------------
module frame_receiver_crc16_check_core_tb;
  import frc16_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned LONG_STALL   = 300;
  localparam int unsigned DRAIN_WAIT   = 4;    // byte -> queue -> output reg, plus margin
  localparam int unsigned N_LIMITS     = 6;
  localparam int unsigned STALL_PHASE  = 3;
  localparam int          DIR_ROWS     = 32;

  // Parser phases of the model
  typedef enum logic [3:0] {
    P_SOF0, P_SOF1, P_ID_LO, P_ID_HI, P_FLAGS, P_SEQ,
    P_LEN_LO, P_LEN_HI, P_PAYLOAD, P_CRC_HI, P_CRC_LO
  } rx_phase_e;

  // Where a directed byte comes from
  typedef enum logic [1:0] {BYTE_LIT, BYTE_CRC_HI, BYTE_CRC_LO, BYTE_CRC_LO_BAD} byte_src_e;

  typedef struct {
    byte_src_e  src;
    logic [7:0] value;
    bit         typed;
    rec_t       want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] data_byte, [23:8] payload_offset, [39:24] packet_id,
  // [47:40] flags_byte, [55:48] sequence_res, [71:56] payload_length
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;   // [1:0] kind

  // Model state
  rx_phase_e   parse_phase;
  logic [15:0] byte_idx;
  logic [15:0] hdr_len;
  logic [15:0] crc_acc;
  logic [7:0]  crc_rx_hi;
  logic [15:0] frame_id;
  logic [7:0]  frame_flags;
  logic [7:0]  frame_seq;
  logic [15:0] len_limit;

  rec_t        expected_q[$];
  dir_row_t    dir_rows [DIR_ROWS];
  logic [15:0] limit_plan [N_LIMITS] = '{16'd0, 16'hFFFF, 16'd7, 16'd512, 16'd1, 16'd40};

  int          mismatches     = 0;
  int          cycle_count    = 0;
  int          live_items     = 0;
  int          bytes_sent     = 0;
  int          n_payload      = 0;
  int          n_good         = 0;
  int          n_bad          = 0;
  int          n_dropped      = 0;
  int          stall_requests = 0;
  int          stalls_served  = 0;
  bit          src_gaps       = 1'b1;
  bit          sink_gaps      = 1'b1;

  frame_receiver_crc16_check_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Bitwise CRC-16/CCITT-FALSE, one data bit per step, MSB first
  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  // Parser model: advance by one accepted byte, return 1 when a beat is due
  function automatic bit parse_rx_byte(input logic [7:0] b, output rec_t res);
    bit emit;
    emit = 1'b0;
    res  = '0;
    case (parse_phase)
      P_SOF1: begin
        if (b == SOF_BYTE1) begin
          crc_acc     = crc_ccitt_byte(crc_acc, b);
          parse_phase = P_ID_LO;
        end else if (b == SOF_BYTE0) begin
          crc_acc     = crc_ccitt_byte(CRC_INIT, SOF_BYTE0);
          parse_phase = P_SOF1;
        end else begin
          parse_phase = P_SOF0;
        end
      end
      P_ID_LO: begin
        crc_acc     = crc_ccitt_byte(crc_acc, b);
        frame_id    = {8'h00, b};
        parse_phase = P_ID_HI;
      end
      P_ID_HI: begin
        crc_acc     = crc_ccitt_byte(crc_acc, b);
        frame_id    = {b, frame_id[7:0]};
        parse_phase = P_FLAGS;
      end
      P_FLAGS: begin
        crc_acc     = crc_ccitt_byte(crc_acc, b);
        frame_flags = b;
        parse_phase = P_SEQ;
      end
      P_SEQ: begin
        crc_acc     = crc_ccitt_byte(crc_acc, b);
        frame_seq   = b;
        parse_phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        crc_acc     = crc_ccitt_byte(crc_acc, b);
        hdr_len     = {8'h00, b};
        parse_phase = P_LEN_HI;
      end
      P_LEN_HI: begin
        crc_acc  = crc_ccitt_byte(crc_acc, b);
        hdr_len  = {b, hdr_len[7:0]};
        byte_idx = '0;
        if (hdr_len > len_limit) begin
          parse_phase = P_SOF0;
          n_dropped++;
        end else if (hdr_len == 16'd0) begin
          parse_phase = P_CRC_HI;
        end else begin
          parse_phase = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        crc_acc            = crc_ccitt_byte(crc_acc, b);
        res.kind           = KIND_DATA;
        res.data_byte      = b;
        res.payload_offset = byte_idx;
        emit               = 1'b1;
        byte_idx           = byte_idx + 16'd1;
        if (byte_idx >= hdr_len) parse_phase = P_CRC_HI;
        n_payload++;
      end
      P_CRC_HI: begin
        crc_rx_hi   = b;
        parse_phase = P_CRC_LO;
      end
      P_CRC_LO: begin
        res.kind           = ({crc_rx_hi, b} == crc_acc) ? KIND_END_GOOD : KIND_END_BAD;
        res.packet_id      = frame_id;
        res.flags_byte     = frame_flags;
        res.sequence_res   = frame_seq;
        res.payload_length = hdr_len;
        emit               = 1'b1;
        if (res.kind == KIND_END_GOOD) n_good++;
        else n_bad++;
        parse_phase = P_SOF0;
        crc_acc     = CRC_INIT;
      end
      default: begin
        if (b == SOF_BYTE0) begin
          crc_acc     = crc_ccitt_byte(CRC_INIT, SOF_BYTE0);
          parse_phase = P_SOF1;
        end else begin
          parse_phase = P_SOF0;
        end
      end
    endcase
    return emit;
  endfunction

  // Offer one byte, wait for the handshake, then predict its beat
  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0, input rec_t want = '0);
    int   gap;
    rec_t res;
    bit   got;
    gap = src_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    // bytes dropped during the hunt do not count as real items
    if (parse_phase != P_SOF0 || b == SOF_BYTE0) live_items++;
    got = parse_rx_byte(b, res);
    if (typed) expected_q.push_back(want);
    else if (got) expected_q.push_back(res);
  endtask

  // Length limit update, only once the block has drained
  task automatic write_len_limit(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    len_limit = v;
    cfg_we_i <= 1'b0;
  endtask

  // Payload followed by the CRC, corrupted now and then
  task automatic send_body(input logic [15:0] len);
    logic [15:0] crc_word;
    repeat (len) push_byte(8'($urandom_range(0, 255)));
    crc_word = crc_acc;
    if ($urandom_range(0, 4) == 0) crc_word = crc_word ^ (16'h0001 << $urandom_range(0, 15));
    push_byte(crc_word[15:8]);
    push_byte(crc_word[7:0]);
  endtask

  // One random frame: mostly well formed, sometimes noisy, broken or cut short
  task automatic send_frame();
    logic [15:0] len;
    int          cut;
    src_gaps = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) push_byte(SOF_BYTE0);
    push_byte(SOF_BYTE0);
    if ($urandom_range(0, 15) == 0) begin
      push_byte(8'($urandom_range(0, 255)));
      return;
    end
    push_byte(SOF_BYTE1);
    repeat (4) push_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: len = 16'($urandom_range(0, 12));
      6:       len = len_limit;
      7:       len = len_limit + 16'd1;   // wraps to zero at the top limit
      8:       len = 16'($urandom_range(0, 48));
      default: len = 16'($urandom_range(0, 65535));
    endcase
    // keep accepted payloads short enough for the run length
    if (len > 16'd600 && len <= len_limit) len = 16'($urandom_range(0, 64));
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    if (parse_phase != P_PAYLOAD && parse_phase != P_CRC_HI) return;
    if ($urandom_range(0, 15) == 0) begin
      cut = $urandom_range(0, len);
      repeat (cut) push_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_body(hdr_len);
  endtask

  // Result checker: each beat against the oldest expectation
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] seen);
    if (want !== seen) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, got kind %0d tdata 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
        check_field("data_byte", 16'(want.data_byte), 16'(m_axis_tdata[7:0]));
        check_field("payload_offset", want.payload_offset, m_axis_tdata[23:8]);
        check_field("packet_id", want.packet_id, m_axis_tdata[39:24]);
        check_field("flags_byte", 16'(want.flags_byte), 16'(m_axis_tdata[47:40]));
        check_field("sequence_res", 16'(want.sequence_res), 16'(m_axis_tdata[55:48]));
        check_field("payload_length", want.payload_length, m_axis_tdata[71:56]);
      end
    end
  end

  // Output side: random hold-offs, plus one long stall on request
  initial begin : sink_side
    int gap;
    int beats;
    m_axis_tready <= 1'b0;
    beats = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ((beats % 32) == 0) sink_gaps = ($urandom_range(0, 3) != 0);
      gap = sink_gaps ? $urandom_range(0, 7) : 0;
      if (stalls_served < stall_requests) begin
        gap = gap + LONG_STALL;
        stalls_served++;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      beats++;
    end
  end

  // Watchdog
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d beats still expected", cycle_count,
             expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [7:0] b;
    int         phase_end;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    parse_phase = P_SOF0;
    byte_idx    = '0;
    hdr_len     = '0;
    crc_acc     = CRC_INIT;
    crc_rx_hi   = '0;
    frame_id    = '0;
    frame_flags = '0;
    frame_seq   = '0;
    len_limit   = 16'(MAX_LEN_RESET);

    // hunt and repeated start, one-byte frame with good CRC,
    // oversize drop at the reset limit, zero-length frame with bad CRC
    dir_rows = '{
      '{BYTE_LIT, 8'hAA, 1'b0, '0},
      '{BYTE_LIT, 8'h01, 1'b0, '0},
      '{BYTE_LIT, 8'hAA, 1'b0, '0},
      '{BYTE_LIT, 8'hAA, 1'b0, '0},
      '{BYTE_LIT, 8'h55, 1'b0, '0},
      '{BYTE_LIT, 8'h00, 1'b0, '0},
      '{BYTE_LIT, 8'h00, 1'b0, '0},
      '{BYTE_LIT, 8'hFF, 1'b0, '0},
      '{BYTE_LIT, 8'h00, 1'b0, '0},
      '{BYTE_LIT, 8'h01, 1'b0, '0},
      '{BYTE_LIT, 8'h00, 1'b0, '0},
      '{BYTE_LIT, 8'hFF, 1'b1,
        {KIND_DATA, 8'hFF, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000}},
      '{BYTE_CRC_HI, 8'h00, 1'b0, '0},
      '{BYTE_CRC_LO, 8'h00, 1'b1,
        {KIND_END_GOOD, 8'h00, 16'h0000, 16'h0000, 8'hFF, 8'h00, 16'h0001}},
      '{BYTE_LIT, 8'hAA, 1'b0, '0},
      '{BYTE_LIT, 8'h55, 1'b0, '0},
      '{BYTE_LIT, 8'hFF, 1'b0, '0},
      '{BYTE_LIT, 8'hFF, 1'b0, '0},
      '{BYTE_LIT, 8'h00, 1'b0, '0},
      '{BYTE_LIT, 8'hFF, 1'b0, '0},
      '{BYTE_LIT, 8'h01, 1'b0, '0},
      '{BYTE_LIT, 8'h02, 1'b0, '0},
      '{BYTE_LIT, 8'hAA, 1'b0, '0},
      '{BYTE_LIT, 8'h55, 1'b0, '0},
      '{BYTE_LIT, 8'hFF, 1'b0, '0},
      '{BYTE_LIT, 8'hFF, 1'b0, '0},
      '{BYTE_LIT, 8'h00, 1'b0, '0},
      '{BYTE_LIT, 8'hFF, 1'b0, '0},
      '{BYTE_LIT, 8'h00, 1'b0, '0},
      '{BYTE_LIT, 8'h00, 1'b0, '0},
      '{BYTE_CRC_HI, 8'h00, 1'b0, '0},
      '{BYTE_CRC_LO_BAD, 8'h00, 1'b1,
        {KIND_END_BAD, 8'h00, 16'h0000, 16'hFFFF, 8'h00, 8'hFF, 16'h0000}}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      case (dir_rows[r].src)
        BYTE_CRC_HI:     b = crc_acc[15:8];
        BYTE_CRC_LO:     b = crc_acc[7:0];
        BYTE_CRC_LO_BAD: b = crc_acc[7:0] ^ 8'h01;
        default:         b = dir_rows[r].value;
      endcase
      push_byte(b, dir_rows[r].typed, dir_rows[r].want);
    end

    // Random frames under each length limit; from the second limit on,
    // the write lands between the low and high length bytes of a frame
    for (int p = 0; p < N_LIMITS; p++) begin
      if (p > 0) begin
        push_byte(SOF_BYTE0);
        push_byte(SOF_BYTE1);
        repeat (5) push_byte(8'($urandom_range(0, 255)));
      end
      write_len_limit(limit_plan[p]);
      if (p > 0) begin
        push_byte(($urandom_range(0, 3) == 0) ? 8'h01 : 8'h00);
        if (parse_phase == P_PAYLOAD || parse_phase == P_CRC_HI) send_body(hdr_len);
      end
      if (p == STALL_PHASE) stall_requests++;
      // every byte on the input counts toward the budget of this phase
      phase_end = bytes_sent + RANDOM_ITEMS / N_LIMITS;
      while (bytes_sent < phase_end) send_frame();
    end

    // Drain
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d bytes (%0d frame bytes) under %0d length limits, incl. mid-frame writes.",
             bytes_sent, live_items, N_LIMITS + 1);
    $display("Saw %0d payload beats, %0d good and %0d bad frame ends, %0d oversize drops.",
             n_payload, n_good, n_bad, n_dropped);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
